/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the barycentric coordinates unit.
// Both macros take a clock, an active-high reset, an antecedent and a
// consequent, and report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BCU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bcu_pkg.sv */
// ----------------------------------------------------------------------------
// bcu_pkg
// Types and fixed constants of the barycentric coordinates unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcu_pkg;

   // Limb width of the split multipliers; each partial product is a signed
   // (LIMB_W+1) by (LIMB_W+1) multiplication.
   localparam int LIMB_W = 34;

   // Result weights are always 32 bits wide.
   localparam int OUT_W = 32;
   localparam int N_COORDS = 12;
   localparam int RSP_TDATA_W = 3 * OUT_W;

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // Control bits that travel alongside the divider pipeline.
   typedef struct packed {
      logic valid;
      logic degenerate;
      logic neg_v;
      logic neg_w;
   } bcu_side_type;

   // One finished result.
   typedef struct packed {
      logic [OUT_W-1:0] weight_w;
      logic [OUT_W-1:0] weight_v;
      logic [OUT_W-1:0] weight_u;
      logic             degenerate;
   } bcu_res_type;

endpackage

/* design/barycentric_coordinates_unit.sv */
// ----------------------------------------------------------------------------
// barycentric_coordinates_unit
// Barycentric weights u, v, w of a 3-D point against a triangle, fully
// pipelined with exact fixed-point arithmetic and saturated Q results.
// ----------------------------------------------------------------------------
//
//   Channel  Ports               Payload
//   -------  ------------------  ----------------------------------------------
//   input    req_tvalid/tready   req_tdata: point x,y,z, corners a, b, c (x,y,z)
//   result   rsp_tvalid/tready   rsp_tdata: weight u, v, w; rsp_tuser: degenerate
//
// One transaction is accepted per cycle while req_tready is high. The
// restoring divider has NS = 4*COORD_WIDTH + 9 + FRAC_BITS stages, one
// quotient bit per stage. Reset is synchronous and active high and clears
// only the valid bits and the divider's side-band control bits. A stall on
// the result side first fills a one-entry skid buffer behind the output
// register; only when that buffer is full does the whole pipeline freeze
// and req_tready drop.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module barycentric_coordinates_unit import bcu_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // From bit 0 up: point_x, point_y, point_z, corner_a_x, corner_a_y,
   // corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y,
   // corner_c_z, each COORD_WIDTH bits, then zero fill to whole bytes.
   input  logic [((N_COORDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // From bit 0 up: weight_u, weight_v, weight_w, 32 bits each.
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // Bit 0: degenerate.
   output logic [0:0]                   rsp_tuser
);

   // Exact widths of every intermediate value.
   localparam int EW = COORD_WIDTH + 1;      // edge vector component
   localparam int PW = 2 * EW;               // component product
   localparam int DW = PW + 2;               // dot product of three terms
   localparam int MW = 2 * DW;               // product of two dot products
   localparam int SW = MW + 1;               // denominator and numerators
   localparam int NS = SW + FRAC_BITS;       // numerator scaled to Q format
   localparam int QW = NS + 1;               // signed quotient
   localparam int UW = NS + 3;               // one minus v minus w
   localparam int N_FRONT = 8;               // stages ahead of the divider

   // The fixed-point value 1.0.
   localparam logic [UW-1:0] ONE_Q = UW'(1) << FRAC_BITS;

   // The whole pipeline advances as long as the skid buffer is empty.
   logic en;
   logic skid_v_ff;
   logic out_v_ff;

   assign en         = ~skid_v_ff;
   assign req_tready = en;

   logic [N_FRONT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_FRONT-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: edge vectors B - A, C - A and P - A.
   // ------------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] crd [N_COORDS];
   logic signed [EW-1:0] e0_ff [3];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];

   for (genvar i = 0; i < N_COORDS; i++) begin : g_unpack
      assign crd[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= EW'(crd[6+i]) - EW'(crd[3+i]);
            e1_ff[i] <= EW'(crd[9+i]) - EW'(crd[3+i]);
            e2_ff[i] <= EW'(crd[i])   - EW'(crd[3+i]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stages 2 and 3: the fifteen component products of the five dot products.
   // ------------------------------------------------------------------------
   logic signed [PW-1:0] prod [15];

   for (genvar i = 0; i < 3; i++) begin : g_comp
      bcu_mul #(.A_W(EW), .B_W(EW)) u_m00 (
         .clock(clock), .en(en), .a(e0_ff[i]), .b(e0_ff[i]), .p(prod[i]));
      bcu_mul #(.A_W(EW), .B_W(EW)) u_m01 (
         .clock(clock), .en(en), .a(e0_ff[i]), .b(e1_ff[i]), .p(prod[3+i]));
      bcu_mul #(.A_W(EW), .B_W(EW)) u_m11 (
         .clock(clock), .en(en), .a(e1_ff[i]), .b(e1_ff[i]), .p(prod[6+i]));
      bcu_mul #(.A_W(EW), .B_W(EW)) u_m20 (
         .clock(clock), .en(en), .a(e2_ff[i]), .b(e0_ff[i]), .p(prod[9+i]));
      bcu_mul #(.A_W(EW), .B_W(EW)) u_m21 (
         .clock(clock), .en(en), .a(e2_ff[i]), .b(e1_ff[i]), .p(prod[12+i]));
   end

   // ------------------------------------------------------------------------
   // Stage 4: dot products d00, d01, d11, d20, d21 in that order.
   // ------------------------------------------------------------------------
   logic signed [DW-1:0] dot_ff [5];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int d = 0; d < 5; d++) begin
            dot_ff[d] <= DW'(prod[3*d]) + DW'(prod[3*d+1]) + DW'(prod[3*d+2]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stages 5 and 6: the six products that form the denominator and the two
   // numerators.
   // ------------------------------------------------------------------------
   logic signed [MW-1:0] mp [6];

   bcu_mul #(.A_W(DW), .B_W(DW)) u_p0011 (
      .clock(clock), .en(en), .a(dot_ff[0]), .b(dot_ff[2]), .p(mp[0]));
   bcu_mul #(.A_W(DW), .B_W(DW)) u_p0101 (
      .clock(clock), .en(en), .a(dot_ff[1]), .b(dot_ff[1]), .p(mp[1]));
   bcu_mul #(.A_W(DW), .B_W(DW)) u_p1120 (
      .clock(clock), .en(en), .a(dot_ff[2]), .b(dot_ff[3]), .p(mp[2]));
   bcu_mul #(.A_W(DW), .B_W(DW)) u_p0121 (
      .clock(clock), .en(en), .a(dot_ff[1]), .b(dot_ff[4]), .p(mp[3]));
   bcu_mul #(.A_W(DW), .B_W(DW)) u_p0021 (
      .clock(clock), .en(en), .a(dot_ff[0]), .b(dot_ff[4]), .p(mp[4]));
   bcu_mul #(.A_W(DW), .B_W(DW)) u_p0120 (
      .clock(clock), .en(en), .a(dot_ff[1]), .b(dot_ff[3]), .p(mp[5]));

   // ------------------------------------------------------------------------
   // Stage 7: denominator and numerators.
   // ------------------------------------------------------------------------
   logic signed [SW-1:0] den_ff;
   logic signed [SW-1:0] nv_ff;
   logic signed [SW-1:0] nw_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= SW'(mp[0]) - SW'(mp[1]);
         nv_ff  <= SW'(mp[2]) - SW'(mp[3]);
         nw_ff  <= SW'(mp[4]) - SW'(mp[5]);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 8: scale the numerators to Q format and split off their signs.
   // The denominator is a Gram determinant and never negative, so its low
   // MW bits are its magnitude.
   // ------------------------------------------------------------------------
   logic signed [NS-1:0] nvs;
   logic signed [NS-1:0] nws;
   logic [NS-1:0]        mag_v_ff;
   logic [NS-1:0]        mag_w_ff;
   logic [MW-1:0]        den_mag_ff;
   bcu_side_type         side_s8;
   logic                 deg_s8_ff;
   logic                 neg_v_s8_ff;
   logic                 neg_w_s8_ff;

   assign nvs = NS'(nv_ff) <<< FRAC_BITS;
   assign nws = NS'(nw_ff) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_v_ff    <= nvs[NS-1] ? NS'(-nvs) : nvs;
         mag_w_ff    <= nws[NS-1] ? NS'(-nws) : nws;
         den_mag_ff  <= den_ff[MW-1:0];
         deg_s8_ff   <= (den_ff == '0);
         neg_v_s8_ff <= nvs[NS-1];
         neg_w_s8_ff <= nws[NS-1];
      end
   end

   assign side_s8.valid      = vld_ff[N_FRONT-1];
   assign side_s8.degenerate = deg_s8_ff;
   assign side_s8.neg_v      = neg_v_s8_ff;
   assign side_s8.neg_w      = neg_w_s8_ff;

   // ------------------------------------------------------------------------
   // Divider: NS stages of magnitude quotient bits. A zero denominator gives
   // a meaningless quotient that the degenerate flag later masks.
   // ------------------------------------------------------------------------
   logic [NS-1:0] quo_v;
   logic [NS-1:0] quo_w;
   bcu_side_type  side_div;

   bcu_div #(.N_W(NS), .D_W(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .num_v    (mag_v_ff),
      .num_w    (mag_w_ff),
      .den      (den_mag_ff),
      .side_in  (side_s8),
      .quo_v    (quo_v),
      .quo_w    (quo_w),
      .side_out (side_div)
   );

   // ------------------------------------------------------------------------
   // Stage A: restore the quotient signs (truncation toward zero).
   // ------------------------------------------------------------------------
   logic signed [QW-1:0] qv_pos;
   logic signed [QW-1:0] qw_pos;
   logic signed [QW-1:0] qv_ff;
   logic signed [QW-1:0] qw_ff;
   logic                 va_ff;
   logic                 deg_a_ff;

   assign qv_pos = $signed({1'b0, quo_v});
   assign qw_pos = $signed({1'b0, quo_w});

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= side_div.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qv_ff    <= side_div.neg_v ? -qv_pos : qv_pos;
         qw_ff    <= side_div.neg_w ? -qw_pos : qw_pos;
         deg_a_ff <= side_div.degenerate;
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: u from the exact quotients; v and w saturate here, u on the way
   // to the output register.
   // ------------------------------------------------------------------------
   function automatic logic [OUT_W-1:0] sat_out(input logic signed [UW-1:0] x);
      logic [UW-OUT_W:0] top;
      top = x[UW-1:OUT_W-1];
      if (top == '0 || top == '1) begin
         return x[OUT_W-1:0];
      end
      return x[UW-1] ? SAT_MIN : SAT_MAX;
   endfunction

   logic signed [UW-1:0] u_sum;
   logic signed [UW-1:0] u_b_ff;
   logic [OUT_W-1:0]     v_b_ff;
   logic [OUT_W-1:0]     w_b_ff;
   logic                 vb_ff;
   logic                 deg_b_ff;

   assign u_sum = $signed(ONE_Q) - UW'(qv_ff) - UW'(qw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_b_ff   <= u_sum;
         v_b_ff   <= deg_a_ff ? '0 : sat_out(UW'(qv_ff));
         w_b_ff   <= deg_a_ff ? '0 : sat_out(UW'(qw_ff));
         deg_b_ff <= deg_a_ff;
      end
   end

   bcu_res_type pipe_res;
   logic        pipe_push;

   assign pipe_res.weight_u   = deg_b_ff ? '0 : sat_out(u_b_ff);
   assign pipe_res.weight_v   = v_b_ff;
   assign pipe_res.weight_w   = w_b_ff;
   assign pipe_res.degenerate = deg_b_ff;
   assign pipe_push           = vb_ff & en;

   // ------------------------------------------------------------------------
   // Output register with a one-entry skid buffer. A result that arrives
   // while the output waits parks in the skid entry; the skid entry always
   // drains first.
   // ------------------------------------------------------------------------
   bcu_res_type out_ff;
   bcu_res_type skid_ff;
   logic        out_free;

   assign out_free = ~out_v_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff | pipe_push;
         skid_v_ff <= 1'b0;
      end else if (pipe_push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_res;
      end else if (pipe_push) begin
         skid_ff <= pipe_res;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = {out_ff.weight_w, out_ff.weight_v, out_ff.weight_u};
   assign rsp_tuser[0] = out_ff.degenerate;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `BCU_ASSERT_IMPL(a_deg_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "degenerate result with nonzero weights")
   `BCU_ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff, "skid entry full while output register empty")
   `BCU_ASSERT_NEXT(a_skid_holds, clock, reset, skid_v_ff && !rsp_tready, skid_v_ff, "skid entry lost during a stall")

endmodule

/* design/bcu_mul.sv */
// ----------------------------------------------------------------------------
// bcu_mul
// Two-stage signed multiplier: limb partial products, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcu_mul import bcu_pkg::*; #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);

   localparam int NA   = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int NB   = (B_W + LIMB_W - 1) / LIMB_W;
   localparam int AX_W = NA * LIMB_W;
   localparam int BX_W = NB * LIMB_W;
   localparam int PP_W = 2 * LIMB_W + 2;
   localparam int P_W  = A_W + B_W;

   logic signed [AX_W-1:0]  a_ext;
   logic signed [BX_W-1:0]  b_ext;
   logic signed [LIMB_W:0]  a_limb [NA];
   logic signed [LIMB_W:0]  b_limb [NB];
   logic signed [PP_W-1:0]  pp_ff  [NA*NB];
   logic signed [P_W-1:0]   acc;
   logic signed [P_W-1:0]   p_ff;

   assign a_ext = AX_W'(a);
   assign b_ext = BX_W'(b);

   // Lower limbs are unsigned, the top limb carries the sign.
   for (genvar k = 0; k < NA; k++) begin : g_alimb
      if (k == NA - 1) begin : g_top
         assign a_limb[k] = {a_ext[AX_W-1], a_ext[k*LIMB_W +: LIMB_W]};
      end else begin : g_low
         assign a_limb[k] = {1'b0, a_ext[k*LIMB_W +: LIMB_W]};
      end
   end

   for (genvar j = 0; j < NB; j++) begin : g_blimb
      if (j == NB - 1) begin : g_top
         assign b_limb[j] = {b_ext[BX_W-1], b_ext[j*LIMB_W +: LIMB_W]};
      end else begin : g_low
         assign b_limb[j] = {1'b0, b_ext[j*LIMB_W +: LIMB_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NA; k++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[k*NB+j] <= a_limb[k] * b_limb[j];
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < NA; k++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (P_W'(pp_ff[k*NB+j]) <<< (LIMB_W * (k + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= acc;
      end
   end

   assign p = p_ff;

endmodule

/* design/bcu_div.sv */
// ----------------------------------------------------------------------------
// bcu_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcu_div import bcu_pkg::*; #(
   parameter int N_W = 153,
   parameter int D_W = 136
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [N_W-1:0]     num_v,
   input  logic [N_W-1:0]     num_w,
   input  logic [D_W-1:0]     den,
   input  bcu_side_type       side_in,
   output logic [N_W-1:0]     quo_v,
   output logic [N_W-1:0]     quo_w,
   output bcu_side_type       side_out
);

   logic [D_W-1:0]  rem_v_ff [N_W];
   logic [D_W-1:0]  rem_w_ff [N_W];
   logic [N_W-1:0]  num_v_ff [N_W];
   logic [N_W-1:0]  num_w_ff [N_W];
   logic [D_W-1:0]  den_ff   [N_W];
   bcu_side_type    side_ff  [N_W];

   for (genvar k = 0; k < N_W; k++) begin : g_stage
      logic [D_W-1:0] rv_src;
      logic [D_W-1:0] rw_src;
      logic [N_W-1:0] nv_src;
      logic [N_W-1:0] nw_src;
      logic [D_W-1:0] d_src;
      bcu_side_type   s_src;
      logic [D_W:0]   sh_v;
      logic [D_W:0]   sh_w;
      logic [D_W+1:0] tr_v;
      logic [D_W+1:0] tr_w;
      logic           ge_v;
      logic           ge_w;

      if (k == 0) begin : g_first
         assign rv_src = '0;
         assign rw_src = '0;
         assign nv_src = num_v;
         assign nw_src = num_w;
         assign d_src  = den;
         assign s_src  = side_in;
      end else begin : g_next
         assign rv_src = rem_v_ff[k-1];
         assign rw_src = rem_w_ff[k-1];
         assign nv_src = num_v_ff[k-1];
         assign nw_src = num_w_ff[k-1];
         assign d_src  = den_ff[k-1];
         assign s_src  = side_ff[k-1];
      end

      // Bring down the next numerator bit and try the subtraction.
      assign sh_v = {rv_src, nv_src[N_W-1]};
      assign sh_w = {rw_src, nw_src[N_W-1]};
      assign tr_v = {1'b0, sh_v} - {2'b00, d_src};
      assign tr_w = {1'b0, sh_w} - {2'b00, d_src};
      assign ge_v = ~tr_v[D_W+1];
      assign ge_w = ~tr_w[D_W+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else if (en) begin
            side_ff[k] <= s_src;
         end
      end

      // The numerator word shifts left and collects quotient bits at the bottom.
      always_ff @(posedge clock) begin
         if (en) begin
            rem_v_ff[k] <= ge_v ? tr_v[D_W-1:0] : sh_v[D_W-1:0];
            rem_w_ff[k] <= ge_w ? tr_w[D_W-1:0] : sh_w[D_W-1:0];
            num_v_ff[k] <= {nv_src[N_W-2:0], ge_v};
            num_w_ff[k] <= {nw_src[N_W-2:0], ge_w};
            den_ff[k]   <= d_src;
         end
      end
   end

   assign quo_v    = num_v_ff[N_W-1];
   assign quo_w    = num_w_ff[N_W-1];
   assign side_out = side_ff[N_W-1];

endmodule

/* test/barycentric_coordinates_unit_tb.sv */
// ----------------------------------------------------------------------------
// barycentric_coordinates_unit_tb
// Self-checking bench for the barycentric coordinates unit: directed corner
// cases and random triangles are streamed in with random gaps on both
// channels, and every result is compared against an exact integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barycentric_coordinates_unit_tb import bcu_pkg::*; ();

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int REQ_W       = ((N_COORDS * COORD_WIDTH + 7) / 8) * 8;
   // Pipeline depth of the block; DRAIN adds the margin.
   localparam int LATENCY     = 4 * COORD_WIDTH + 9 + FRAC_BITS + 11;
   localparam int DRAIN       = LATENCY + 50;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 630;
   localparam int REPORT_MAX  = 10;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   // Order: point x,y,z, then corners a, b and c, each x,y,z.
   typedef coord_type query_type [N_COORDS];
   typedef logic signed [255:0] wide_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]          rsp_tuser;

   bcu_res_type weights_pending [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          idle_off;

   barycentric_coordinates_unit #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Saturates an exact value to the signed 32-bit weight range.
   function automatic logic [OUT_W-1:0] clamp_weight(input wide_type x);
      wide_type hi;
      wide_type lo;
      hi = $signed(SAT_MAX);
      lo = $signed(SAT_MIN);
      if (x > hi) return SAT_MAX;
      if (x < lo) return SAT_MIN;
      return x[OUT_W-1:0];
   endfunction

   // Exact barycentric weights. All products fit comfortably in 256 bits,
   // and SystemVerilog signed division truncates toward zero as required.
   function automatic bcu_res_type predict_weights(input query_type q);
      wide_type p [3];
      wide_type a [3];
      wide_type b [3];
      wide_type c [3];
      wide_type e0 [3];
      wide_type e1 [3];
      wide_type e2 [3];
      wide_type d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu, one;
      bcu_res_type r;
      for (int i = 0; i < 3; i++) begin
         p[i] = q[i];
         a[i] = q[3 + i];
         b[i] = q[6 + i];
         c[i] = q[9 + i];
         e0[i] = b[i] - a[i];
         e1[i] = c[i] - a[i];
         e2[i] = p[i] - a[i];
      end
      d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
      d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
      d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d20 = e2[0] * e0[0] + e2[1] * e0[1] + e2[2] * e0[2];
      d21 = e2[0] * e1[0] + e2[1] * e1[1] + e2[2] * e1[2];
      den = d00 * d11 - d01 * d01;
      if (den == 0) begin
         r.weight_u   = '0;
         r.weight_v   = '0;
         r.weight_w   = '0;
         r.degenerate = 1'b1;
         return r;
      end
      nv  = (d11 * d20 - d01 * d21) <<< FRAC_BITS;
      nw  = (d00 * d21 - d01 * d20) <<< FRAC_BITS;
      one = wide_type'(1) <<< FRAC_BITS;
      qv  = nv / den;
      qw  = nw / den;
      // u comes from the unsaturated quotients.
      qu  = one - qv - qw;
      r.weight_u   = clamp_weight(qu);
      r.weight_v   = clamp_weight(qv);
      r.weight_w   = clamp_weight(qw);
      r.degenerate = 1'b0;
      return r;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (idle_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result-side back-pressure with the same gap profile.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // Result checker: each accepted transaction is matched against the
   // oldest pending expectation.
   always @(posedge clock) begin
      bcu_res_type want;
      bcu_res_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.weight_u   = rsp_tdata[OUT_W-1:0];
         got.weight_v   = rsp_tdata[2*OUT_W-1:OUT_W];
         got.weight_w   = rsp_tdata[3*OUT_W-1:2*OUT_W];
         got.degenerate = rsp_tuser[0];
         if (weights_pending.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: u=%h v=%h w=%h deg=%b",
                        got.weight_u, got.weight_v, got.weight_w, got.degenerate);
         end else begin
            want = weights_pending.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"mismatch: expected u=%h v=%h w=%h deg=%b, ",
                            "got u=%h v=%h w=%h deg=%b"},
                           want.weight_u, want.weight_v, want.weight_w,
                           want.degenerate, got.weight_u, got.weight_v,
                           got.weight_w, got.degenerate);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** barycentric_coordinates_unit: FAILED **");
         $finish;
      end
   end

   // Sends one query and records its expected weights once it is accepted.
   // The valid stays high across back-to-back transactions.
   task automatic send_query(input query_type q);
      int gap;
      logic [REQ_W-1:0] packed_q;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      packed_q = '0;
      for (int i = 0; i < N_COORDS; i++)
         packed_q[i*COORD_WIDTH +: COORD_WIDTH] = q[i];
      req_tvalid <= 1'b1;
      req_tdata  <= packed_q;
      do @(posedge clock); while (!req_tready);
      weights_pending.insert(weights_pending.size(), predict_weights(q));
   endtask

   task automatic set_triangle(output query_type q, input coord_type px, py, pz,
                               ax, ay, az, bx, by, bz, cx, cy, cz);
      q[0] = px; q[1] = py; q[2] = pz;
      q[3] = ax; q[4] = ay; q[5] = az;
      q[6] = bx; q[7] = by; q[8] = bz;
      q[9] = cx; q[10] = cy; q[11] = cz;
   endtask

   function automatic coord_type rand_full();
      return coord_type'($urandom());
   endfunction

   // Signed value within +/- 2^bits.
   function automatic coord_type rand_span(input int bits);
      int unsigned m;
      m = (bits >= 31) ? 32'hFFFF_FFFF : ((32'd1 << (bits + 1)) - 1);
      return coord_type'($urandom() & m) - coord_type'(m >> 1);
   endfunction

   localparam coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam coord_type C_ONE = 32'sh0001_0000;

   // Corner values of the coordinate range and all-zero input.
   task automatic test_extremes();
      query_type q;
      set_triangle(q, 0,0,0, 0,0,0, 0,0,0, 0,0,0);
      send_query(q);
      for (int i = 0; i < N_COORDS; i++) q[i] = C_MAX;
      send_query(q);
      for (int i = 0; i < N_COORDS; i++) q[i] = C_MIN;
      send_query(q);
      set_triangle(q, C_MAX,C_MIN,C_MAX, C_MIN,C_MIN,C_MIN,
                   C_MAX,C_MIN,C_MIN, C_MIN,C_MAX,C_MAX);
      send_query(q);
      set_triangle(q, C_MIN,C_MAX,C_MIN, C_MAX,C_MAX,C_MAX,
                   C_MIN,C_MAX,C_MAX, C_MAX,C_MIN,C_MIN);
      send_query(q);
      set_triangle(q, -1,-1,-1, C_MIN,0,C_MAX, C_MAX,C_MIN,0, 0,C_MAX,C_MIN);
      send_query(q);
   endtask

   // Unit triangle with the point on each corner, over the interior and outside.
   task automatic test_unit_triangle();
      query_type q;
      set_triangle(q, 0,0,0, 0,0,0, C_ONE,0,0, 0,C_ONE,0);
      send_query(q);
      set_triangle(q, C_ONE,0,0, 0,0,0, C_ONE,0,0, 0,C_ONE,0);
      send_query(q);
      set_triangle(q, 0,C_ONE,0, 0,0,0, C_ONE,0,0, 0,C_ONE,0);
      send_query(q);
      set_triangle(q, C_ONE/3,C_ONE/3,C_ONE, 0,0,0, C_ONE,0,0, 0,C_ONE,0);
      send_query(q);
      set_triangle(q, -C_ONE*5,C_ONE*7,3, 0,0,0, C_ONE,0,0, 0,C_ONE,0);
      send_query(q);
      // Weights that need rounding toward zero in both signs.
      set_triangle(q, 1,-1,0, 0,0,0, 3*C_ONE,0,0, 0,7*C_ONE,0);
      send_query(q);
   endtask

   // Degenerate triangles: coincident and collinear corners.
   task automatic test_degenerate();
      query_type q;
      set_triangle(q, 5,6,7, 100,200,300, 100,200,300, 100,200,300);
      send_query(q);
      set_triangle(q, 5,6,7, 0,0,0, C_ONE,C_ONE,C_ONE, 2*C_ONE,2*C_ONE,2*C_ONE);
      send_query(q);
      set_triangle(q, C_MAX,C_MIN,0, C_MIN,C_MIN,C_MIN, C_MAX,C_MAX,C_MAX, 0,0,0);
      send_query(q);
      set_triangle(q, 1,2,3, 7,7,7, 7,7,7, -9,4,C_MAX);
      send_query(q);
   endtask

   // Tiny triangles against far points drive the weights into saturation,
   // including u overflowing while v and w still fit.
   task automatic test_saturation();
      query_type q;
      set_triangle(q, C_MAX,C_MAX,0, 0,0,0, 1,0,0, 0,1,0);
      send_query(q);
      set_triangle(q, C_MIN,C_MIN,0, 0,0,0, 1,0,0, 0,1,0);
      send_query(q);
      set_triangle(q, C_MAX,C_MIN,C_MAX, 0,0,0, 1,0,0, 0,1,0);
      send_query(q);
      set_triangle(q, 20000,20000,0, 0,0,0, 1,0,0, 0,1,0);
      send_query(q);
      set_triangle(q, -20000,-20000,0, 0,0,0, 1,0,0, 0,1,0);
      send_query(q);
   endtask

   task automatic test_random();
      query_type q;
      int kind;
      int bits;
      coord_type k;
      for (int n = 0; n < N_RANDOM; n++) begin
         // Stretches without any idling on either side.
         idle_off = (n % 150) >= 120;
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            for (int i = 0; i < N_COORDS; i++) q[i] = rand_full();
         end else if (kind < 70) begin
            bits = $urandom_range(4, 30);
            for (int i = 0; i < N_COORDS; i++) q[i] = rand_span(bits);
         end else if (kind < 85) begin
            // Point near a moderate triangle, weights mostly in range.
            for (int i = 3; i < N_COORDS; i++) q[i] = rand_span(20);
            for (int i = 0; i < 3; i++)
               q[i] = q[3 + i] + rand_span(18);
         end else if (kind < 95) begin
            // Collinear: C = A + k * (B - A).
            for (int i = 0; i < 9; i++) q[i] = rand_span(14);
            k = rand_span(3);
            for (int i = 0; i < 3; i++)
               q[9 + i] = q[3 + i] + k * (q[6 + i] - q[3 + i]);
            if ($urandom_range(0, 3) == 0)
               for (int i = 0; i < 3; i++) q[6 + i] = q[3 + i];
         end else begin
            // Very small triangle, far point.
            for (int i = 3; i < 6; i++) q[i] = rand_span(20);
            for (int i = 6; i < N_COORDS; i++) q[i] = q[i % 3 + 3] + rand_span(2);
            for (int i = 0; i < 3; i++) q[i] = rand_full();
         end
         send_query(q);
      end
      idle_off = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      idle_off       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_unit_triangle();
      test_degenerate();
      test_saturation();
      test_random();

      req_tvalid <= 1'b0;
      while (weights_pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (mismatch_count == 0 && weights_pending.size() == 0) begin
         $display("** barycentric_coordinates_unit: PASSED **");
      end else begin
         $display("** barycentric_coordinates_unit: FAILED **");
      end
      $finish;
   end

endmodule
